>>> rtl/tsv_pkg.sv
// Package with shared types, constants and helpers of the SYN-ACK verifier.
package tsv_pkg;

    localparam int TableEntries = 16384;
    localparam int TableWays    = 4;
    localparam int Sets         = TableEntries / TableWays;
    localparam int SetW         = $clog2(Sets);
    localparam int WayW         = (TableWays > 1) ? $clog2(TableWays) : 1;
    localparam int RankW        = (TableWays > 1) ? $clog2(TableWays) : 1;
    localparam logic [63:0] TtlReset = 64'd60000000000;

    typedef enum logic [2:0] {
        EV_PARSE_FAIL  = 3'd0,
        EV_OTHER_TCP   = 3'd1,
        EV_SYN_STORED  = 3'd2,
        EV_VERIFIED    = 3'd3,
        EV_UNSOLICITED = 3'd4,
        EV_STALE       = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        OP_PASS   = 2'd0,
        OP_STORE  = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    // Work handed from the classifier to the table engine.
    typedef struct packed {
        op_t         op;
        event_t      ev;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [63:0] now;
    } cmd_t;

    typedef struct packed {
        logic       verdict;
        logic [2:0] event_res;
    } res_t;

    typedef struct packed {
        logic [63:0]      addrs;
        logic [31:0]      ports;
        logic [63:0]      stamp;
        logic             valid;
        logic [RankW-1:0] rank;
    } way_t;

    // Set index: 32-bit XOR fold modulo the number of sets.
    function automatic logic [SetW-1:0] set_index(input logic [63:0] addrs,
                                                  input logic [31:0] ports);
        logic [31:0] x;
        x = addrs[63:32] ^ addrs[31:0] ^ ports;
        return SetW'(x % 32'(Sets));
    endfunction

endpackage

>>> rtl/tsv_if.sv
// Valid/ready channel interfaces for packet headers and verdicts.
interface tsv_in_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [15:0] ether_type;
    logic [3:0]  ip_version;
    logic [7:0]  ip_protocol;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
    logic [15:0] frame_length;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  tcp_flags;
    logic [63:0] arrival_time;
    modport source (input clk, output valid, input ready, output ether_type, ip_version,
        ip_protocol, ip_header_words, tcp_header_words, frame_length, source_address,
        destination_address, source_port, destination_port, tcp_flags, arrival_time);
    modport sink (input clk, input valid, output ready, input ether_type, ip_version,
        ip_protocol, ip_header_words, tcp_header_words, frame_length, source_address,
        destination_address, source_port, destination_port, tcp_flags, arrival_time);
endinterface

interface tsv_out_if (input logic clk);
    logic       valid;
    logic       ready;
    logic       verdict;
    logic [2:0] event_res;
    modport source (input clk, output valid, input ready, output verdict, event_res);
    modport sink (input clk, input valid, output ready, input verdict, event_res);
endinterface

>>> rtl/tsv_front.sv
// Header checker and classifier feeding a two-entry command queue.
module tsv_front
    import tsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tsv_in_if.sink      in_ch,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);
    cmd_t       q_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    logic       ok, syn, ack;
    logic [17:0] ihl, doff, len;
    cmd_t       c;

    always_comb
    begin
        len  = {2'b0, in_ch.frame_length};
        ihl  = {12'b0, in_ch.ip_header_words, 2'b0};
        doff = {12'b0, in_ch.tcp_header_words, 2'b0};
        ok = (in_ch.ether_type == 16'h0800) && (in_ch.ip_version == 4'd4)
            && (in_ch.ip_protocol == 8'd6) && (len >= 18'd34)
            && (ihl >= 18'd20) && (doff >= 18'd20)
            && (18'd14 + ihl + 18'd20 <= len) && (18'd14 + ihl + doff <= len);
        syn = in_ch.tcp_flags[1];
        ack = in_ch.tcp_flags[4];
        c.now = in_ch.arrival_time;
        if (!ok)
        begin
            c.op = OP_PASS; c.ev = EV_PARSE_FAIL;
        end
        else if (syn && !ack)
        begin
            c.op = OP_STORE; c.ev = EV_SYN_STORED;
        end
        else if (syn && ack)
        begin
            c.op = OP_LOOKUP; c.ev = EV_UNSOLICITED;
        end
        else
        begin
            c.op = OP_PASS; c.ev = EV_OTHER_TCP;
        end
        if (c.op == OP_LOOKUP)
        begin
            c.addrs = {in_ch.destination_address, in_ch.source_address};
            c.ports = {in_ch.destination_port, in_ch.source_port};
        end
        else
        begin
            c.addrs = {in_ch.source_address, in_ch.destination_address};
            c.ports = {in_ch.source_port, in_ch.destination_port};
        end
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop = cmd_valid && cmd_ready;
    assign cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= c;
        end
    end
endmodule

>>> rtl/tsv_table.sv
// Set-associative SYN token table with per-set LRU and a registered result.
module tsv_table
    import tsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] ttl,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    tsv_out_if.source   out_ch,
    output logic        busy
);
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_READ  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    // One set per row; all ways of a set are read and written together.
    way_t mem [Sets][TableWays];
    way_t rd_reg [TableWays];
    way_t wr_row [TableWays];

    state_t          state_reg, state_next;
    logic [SetW:0]   clr_reg, clr_next;
    cmd_t            cur_reg;
    logic [SetW-1:0] set_reg;
    logic            out_valid_reg, out_valid_next;
    res_t            res_reg, res_next;
    logic            wr_en;
    logic [SetW-1:0] wr_addr;
    logic            hit;
    logic [WayW-1:0] hit_way, free_way, lru_way, tgt;
    logic            has_free;
    logic [RankW:0]  old_rank;
    logic [63:0]     age;

    // A result that leaves in this cycle frees the result register for the next command.
    assign cmd_ready = (state_reg == ST_READ) && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.verdict = res_reg.verdict;
    assign out_ch.event_res = res_reg.event_res;
    assign busy = out_valid_reg || (state_reg != ST_READ) || cmd_valid;

    always_comb
    begin
        hit = 1'b0; hit_way = '0; has_free = 1'b0; free_way = '0; lru_way = '0;
        for (int w = TableWays - 1; w >= 0; w--)
        begin
            if (rd_reg[w].valid && rd_reg[w].addrs == cur_reg.addrs
                && rd_reg[w].ports == cur_reg.ports)
            begin
                hit = 1'b1; hit_way = WayW'(w);
            end
            if (!rd_reg[w].valid)
            begin
                has_free = 1'b1; free_way = WayW'(w);
            end
        end
        for (int w = 1; w < TableWays; w++)
        begin
            if (rd_reg[w].rank > rd_reg[lru_way].rank)
            begin
                lru_way = WayW'(w);
            end
        end
        if (hit)
        begin
            tgt = hit_way; old_rank = {1'b0, rd_reg[hit_way].rank};
        end
        else if (has_free)
        begin
            tgt = free_way; old_rank = (RankW + 1)'(TableWays);
        end
        else
        begin
            tgt = lru_way; old_rank = {1'b0, rd_reg[lru_way].rank};
        end
        age = cur_reg.now - rd_reg[hit_way].stamp;

        wr_row = rd_reg;
        wr_en = 1'b0;
        wr_addr = set_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        state_next = state_reg;
        clr_next = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                for (int w = 0; w < TableWays; w++)
                begin
                    wr_row[w].valid = 1'b0;
                    wr_row[w].rank = '0;
                end
                wr_en = 1'b1;
                wr_addr = clr_reg[SetW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SetW + 1)'(Sets - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                out_valid_next = 1'b1;
                state_next = ST_READ;
                res_next.event_res = cur_reg.ev;
                res_next.verdict = 1'b0;
                case (cur_reg.op)
                    OP_STORE:
                    begin
                        wr_en = 1'b1;
                        for (int w = 0; w < TableWays; w++)
                        begin
                            if (WayW'(w) != tgt && rd_reg[w].valid
                                && {1'b0, rd_reg[w].rank} < old_rank
                                && rd_reg[w].rank != RankW'(TableWays - 1))
                            begin
                                wr_row[w].rank = rd_reg[w].rank + 1'b1;
                            end
                        end
                        wr_row[tgt].addrs = cur_reg.addrs;
                        wr_row[tgt].ports = cur_reg.ports;
                        wr_row[tgt].stamp = cur_reg.now;
                        wr_row[tgt].valid = 1'b1;
                        wr_row[tgt].rank = '0;
                    end
                    OP_LOOKUP:
                    begin
                        res_next.verdict = 1'b1;
                        if (hit)
                        begin
                            wr_en = 1'b1;
                            wr_row[hit_way].valid = 1'b0;
                            if (age > ttl)
                            begin
                                res_next.event_res = EV_STALE;
                            end
                            else
                            begin
                                res_next.event_res = EV_VERIFIED;
                                res_next.verdict = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd_valid && cmd_ready)
        begin
            cur_reg <= cmd;
            set_reg <= set_index(cmd.addrs, cmd.ports);
            rd_reg  <= mem[set_index(cmd.addrs, cmd.ports)];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
    end
endmodule

>>> rtl/tcp_synack_verifier_top.sv
// Top level of the TCP SYN-ACK verifier: config register, front end and table engine.
//
// Usage: header summaries enter on hdr_in (valid/ready); one verdict per
// transaction leaves on res_out (valid/ready) in arrival order. The TTL is
// written over the APB port at address 0 (64-bit data); the user must write it
// only while idle, as the block does not enforce this. A front end checks and
// classifies each header and parks it in a two-entry queue, so it keeps taking
// transactions while the table engine is busy. The table engine reads one whole
// set into a register when it accepts a transaction, then updates and writes it
// back while the verdict goes into the result register, and it takes no new
// transaction before that. After reset the engine sweeps every set (4096 at
// the default size) to clear valid bits and ranks; the queue may fill meanwhile.
// When the receiver stalls, the result register holds and the engine waits;
// the queue then fills and hdr_in drops ready.
module tcp_synack_verifier_top
    import tsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tsv_in_if.sink      hdr_in,
    tsv_out_if.source   res_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0] ttl_reg;
    logic        cmd_valid, cmd_ready, busy;
    cmd_t        cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == 4'd0) ? ttl_reg : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= TtlReset;
        end
        else if (psel && penable && pwrite && paddr == 4'd0)
        begin
            ttl_reg <= pwdata;
        end
    end

    tsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (hdr_in),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tsv_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ttl       (ttl_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_ch    (res_out),
        .busy      (busy)
    );

`ifndef ASSERT_OFF
    a_evt_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> res_out.event_res <= EV_STALE)
        else $error("event code out of range");
    a_drop_codes: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && res_out.verdict |->
        (res_out.event_res == EV_UNSOLICITED || res_out.event_res == EV_STALE))
        else $error("drop with a passing event");
    a_pass_codes: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid
        && (res_out.event_res == EV_UNSOLICITED || res_out.event_res == EV_STALE)
        |-> res_out.verdict)
        else $error("unsolicited or stale passed");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid |-> busy)
        else $error("busy low with a pending result");
`endif
endmodule
